### sv/tps_pkg.sv
`timescale 1ns / 1ps

package tps_pkg;

  // Field widths of the pixel and result items.
  localparam int POS_W   = 10;
  localparam int CH_W    = 8;
  localparam int IDX_W   = 20;
  localparam int COLOR_W = 16;

  // Register widths.
  localparam int WIT_W   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Tile geometry: 8x8 pixels, 64 words per tile.
  localparam int TILE_SHIFT = 3;
  localparam int MORTON_W   = 2 * TILE_SHIFT;
  localparam int TILE_W     = IDX_W - MORTON_W;

  // Default coordinate range.
  localparam int MAX_DIM_DEFAULT = 1024;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IN_TILES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT   = 1'd1;

  // Pixel format codes.
  localparam logic FMT_RGB565   = 1'b0;
  localparam logic FMT_RGBA4444 = 1'b1;

  // Reset values of the registers.
  localparam logic [WIT_W-1:0] WIT_RESET = 8'd1;
  localparam logic             FMT_RESET = FMT_RGB565;

  // One input pixel; pos_x sits in the lowest bits.
  typedef struct packed {
    logic [CH_W-1:0]  alpha;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_x;
  } pix_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [WIT_W-1:0] width_in_tiles;
    logic             pixel_format;
  } cfg_t;

  localparam int PIX_W       = $bits(pix_t);
  localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
  localparam int OUT_W       = IDX_W + COLOR_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

endpackage

### sv/tiled_pixel_swizzle_pack.sv
`timescale 1ns / 1ps

// Channel   Direction  Width  Contents
// s_axis    in         56     pixel: pos_x, pos_y, red, green, blue, alpha
// m_axis    out        40     result: word_index, packed_color
// cfg       in         1+8    register writes: width_in_tiles, pixel_format
//
// One pixel per cycle while the result is not stalled; a pixel's result passes
// through the input register, then the result register, before it can leave.
// The address multiply and the three alpha multiplies sit in the one
// combinational stage between those two registers.
// Reset clears the valid flags and sets width_in_tiles to 1 and RGB565 mode.
// A stalled result holds; the input register still takes a pixel while empty.

module tiled_pixel_swizzle_pack
  import tps_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Fields from bit 0 up: pos_x[9:0], pos_y[19:10], red[27:20], green[35:28],
  // blue[43:36], alpha[51:44], zero fill.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // Fields from bit 0 up: word_index[19:0], packed_color[35:20], zero fill.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t cfg_q;

  pix_t pix_q;
  logic in_valid_q;

  logic [IDX_W-1:0]   index_d, index_q;
  logic [COLOR_W-1:0] color_d, color_q;
  logic               out_valid_q;

  logic out_load;
  logic in_load;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_in_tiles <= WIT_RESET;
      cfg_q.pixel_format   <= FMT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH_IN_TILES: cfg_q.width_in_tiles <= cfg_data_i[WIT_W-1:0];
        CFG_PIXEL_FORMAT:   cfg_q.pixel_format   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register loads when empty or being drained.
  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign in_load         = !in_valid_q || out_load;
  assign s_axis_tready_o = in_load;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && s_axis_tvalid_i) begin
      pix_q <= s_axis_tdata_i[PIX_W-1:0];
    end
  end

  // Address and color logic.
  tps_addr #(
    .MAX_DIM(MAX_DIM)
  ) u_addr (
    .pos_x_i         (pix_q.pos_x),
    .pos_y_i         (pix_q.pos_y),
    .width_in_tiles_i(cfg_q.width_in_tiles),
    .word_index_o    (index_d)
  );

  tps_color u_color (
    .red_i         (pix_q.red),
    .green_i       (pix_q.green),
    .blue_i        (pix_q.blue),
    .alpha_i       (pix_q.alpha),
    .pixel_format_i(cfg_q.pixel_format),
    .packed_color_o(color_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      index_q <= index_d;
      color_q <= color_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - OUT_W)'(0), color_q, index_q};

  // A pixel in the input register moves on whenever the result side is free.
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_load) |=> out_valid_q)
    else $error("pixel in input register was not moved to result register");

  // A pixel held behind a stalled result is not dropped.
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |=> in_valid_q)
    else $error("pixel lost while result was stalled");

  // The input side refuses a transfer only when both registers are full and stalled.
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input refused a transfer with room available");

endmodule

### sv/tps_addr.sv
`timescale 1ns / 1ps

module tps_addr
  import tps_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [WIT_W-1:0] width_in_tiles_i,
  output logic [IDX_W-1:0] word_index_o
);

  // Coordinates wrap at MAX_DIM, which must be a power of two; the block does not check it.
  localparam logic [POS_W-1:0] COORD_MASK = POS_W'(MAX_DIM - 1);
  localparam int TC_W   = POS_W - TILE_SHIFT;
  localparam int PROD_W = TC_W + WIT_W;

  logic [POS_W-1:0]    x, y;
  logic [TC_W-1:0]     tile_x, tile_y;
  logic [PROD_W-1:0]   row_base;
  logic [TILE_W-1:0]   tile_num;
  logic [MORTON_W-1:0] morton;

  assign x = pos_x_i & COORD_MASK;
  assign y = pos_y_i & COORD_MASK;

  // Row-major tile number; bits above the index width drop out.
  assign tile_x   = x[POS_W-1:TILE_SHIFT];
  assign tile_y   = y[POS_W-1:TILE_SHIFT];
  assign row_base = PROD_W'(tile_y) * PROD_W'(width_in_tiles_i);
  assign tile_num = row_base[TILE_W-1:0] + TILE_W'(tile_x);

  // Z-order inside the tile, x in the even bit positions.
  assign morton = {y[2], x[2], y[1], x[1], y[0], x[0]};

  assign word_index_o = {tile_num, morton};

endmodule

### sv/tps_color.sv
`timescale 1ns / 1ps

module tps_color
  import tps_pkg::*;
(
  input  logic [CH_W-1:0]    red_i,
  input  logic [CH_W-1:0]    green_i,
  input  logic [CH_W-1:0]    blue_i,
  input  logic [CH_W-1:0]    alpha_i,
  input  logic               pixel_format_i,
  output logic [COLOR_W-1:0] packed_color_o
);

  localparam int P_W = 2 * CH_W;

  // Exact floor(c*a/255): for any product of two 8-bit values,
  // (p + 1 + (p >> 8)) >> 8 equals p / 255.
  function automatic logic [CH_W-1:0] premul(input logic [CH_W-1:0] c,
                                             input logic [CH_W-1:0] a);
    logic [P_W-1:0] p;
    logic [P_W:0]   s;
    p = P_W'(c) * P_W'(a);
    s = (P_W+1)'(p) + (P_W+1)'(1) + (P_W+1)'(p >> CH_W);
    return s[P_W-1:CH_W];
  endfunction

  logic [CH_W-1:0] pr, pg, pb;

  assign pr = premul(red_i, alpha_i);
  assign pg = premul(green_i, alpha_i);
  assign pb = premul(blue_i, alpha_i);

  // Pack the color in the selected layout.
  always_comb begin
    case (pixel_format_i)
      FMT_RGB565:   packed_color_o = {pr[7:3], pg[7:2], pb[7:3]};
      FMT_RGBA4444: packed_color_o = {red_i[7:4], green_i[7:4], blue_i[7:4], alpha_i[7:4]};
      default:      packed_color_o = '0;
    endcase
  end

endmodule
